[rtl/ecr_pkg.sv]
package ecr_pkg;

   // width of one partial-product slice in the wide multipliers
   localparam int CHUNK_BITS = 32;

   // item classification made at the front
   typedef struct packed {
      logic degen;       // positions coincide or mass sum is zero
      logic mass_zero;   // mass sum is zero
   } flag_type;

endpackage

[rtl/ecr_ifs.sv]
// Request channel: two discs, positions, velocities and masses
interface ecr_req_if #(
   parameter int WORD_BITS = 24,
   parameter int MASS_BITS = 16
);
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] first_pos_x;
   logic signed [WORD_BITS-1:0] first_pos_y;
   logic signed [WORD_BITS-1:0] second_pos_x;
   logic signed [WORD_BITS-1:0] second_pos_y;
   logic signed [WORD_BITS-1:0] first_vel_x;
   logic signed [WORD_BITS-1:0] first_vel_y;
   logic signed [WORD_BITS-1:0] second_vel_x;
   logic signed [WORD_BITS-1:0] second_vel_y;
   logic [MASS_BITS-1:0]        first_mass;
   logic [MASS_BITS-1:0]        second_mass;

   modport source (
      output valid, first_pos_x, first_pos_y, second_pos_x, second_pos_y,
             first_vel_x, first_vel_y, second_vel_x, second_vel_y,
             first_mass, second_mass,
      input  ready
   );
   modport sink (
      input  valid, first_pos_x, first_pos_y, second_pos_x, second_pos_y,
             first_vel_x, first_vel_y, second_vel_x, second_vel_y,
             first_mass, second_mass,
      output ready
   );
endinterface

// Response channel: velocities after impact and contact point
interface ecr_rsp_if #(
   parameter int WORD_BITS = 24
);
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] new_first_vel_x;
   logic signed [WORD_BITS-1:0] new_first_vel_y;
   logic signed [WORD_BITS-1:0] new_second_vel_x;
   logic signed [WORD_BITS-1:0] new_second_vel_y;
   logic signed [WORD_BITS-1:0] contact_x;
   logic signed [WORD_BITS-1:0] contact_y;
   logic                        degenerate;

   modport source (
      output valid, new_first_vel_x, new_first_vel_y, new_second_vel_x,
             new_second_vel_y, contact_x, contact_y, degenerate,
      input  ready
   );
   modport sink (
      input  valid, new_first_vel_x, new_first_vel_y, new_second_vel_x,
             new_second_vel_y, contact_x, contact_y, degenerate,
      output ready
   );
endinterface

[rtl/ecr_front.sv]
module ecr_front #(
   parameter int WORD_BITS = 24,
   parameter int MASS_BITS = 16
) (
   ecr_req_if.sink                       req_bus,
   input  logic                          queue_full,
   output logic                          push,
   output logic [12*WORD_BITS+2*MASS_BITS+5:0] entry
);
   localparam int W   = WORD_BITS;
   localparam int DW1 = W + 1;

   logic signed [DW1-1:0] dx, dy, dvx, dvy;
   ecr_pkg::flag_type     flags;

   // take an item whenever the queue has room
   assign req_bus.ready = !queue_full;
   assign push          = req_bus.valid && !queue_full;

   // separation and relative velocity
   assign dx  = DW1'(req_bus.first_pos_x) - DW1'(req_bus.second_pos_x);
   assign dy  = DW1'(req_bus.first_pos_y) - DW1'(req_bus.second_pos_y);
   assign dvx = DW1'(req_bus.first_vel_x) - DW1'(req_bus.second_vel_x);
   assign dvy = DW1'(req_bus.first_vel_y) - DW1'(req_bus.second_vel_y);

   // classify: no mass, or discs on top of each other
   always_comb begin
      flags.mass_zero = (req_bus.first_mass == '0) && (req_bus.second_mass == '0);
      flags.degen     = flags.mass_zero || ((dx == '0) && (dy == '0));
   end

   assign entry = {req_bus.first_pos_x, req_bus.first_pos_y,
                   req_bus.second_pos_x, req_bus.second_pos_y,
                   req_bus.first_vel_x, req_bus.first_vel_y,
                   req_bus.second_vel_x, req_bus.second_vel_y,
                   req_bus.first_mass, req_bus.second_mass,
                   dx, dy, dvx, dvy, flags};
endmodule

[rtl/ecr_queue.sv]
module ecr_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output logic [WIDTH-1:0] rd_data
);
   localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTRW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;

   assign full      = (count_ff == CNTW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign rd_data   = mem_ff[rd_ptr_ff];

   // advance pointers with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the item
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(DEPTH))
      else $error("queue count beyond depth");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("pop from empty queue");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");
endmodule

[rtl/ecr_delay.sv]
module ecr_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);
   logic [WIDTH-1:0] line_ff [DEPTH];

   // shift the line on each advance
   always_ff @(posedge clock) begin
      if (en) begin
         line_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   assign dout = line_ff[DEPTH-1];
endmodule

[rtl/ecr_mul.sv]
module ecr_mul #(
   parameter int A_BITS = 64,
   parameter int B_BITS = 32
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [A_BITS-1:0]        a,
   input  logic [B_BITS-1:0]        b,
   output logic [A_BITS+B_BITS-1:0] p
);
   localparam int CH  = ecr_pkg::CHUNK_BITS;
   localparam int NC  = (A_BITS + CH - 1) / CH;
   localparam int PAD = NC * CH;
   localparam int PPW = CH + B_BITS;
   localparam int PW  = A_BITS + B_BITS;

   logic [PAD-1:0] a_pad;
   logic [PPW-1:0] pp_ff [NC];
   logic [PW-1:0]  sum;
   logic [PW-1:0]  sum_ff;

   assign a_pad = PAD'(a);

   // slice products
   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NC; i++) begin
            pp_ff[i] <= PPW'(a_pad[i*CH +: CH]) * PPW'(b);
         end
      end
   end

   // align and add the slices
   always_comb begin
      sum = '0;
      for (int i = 0; i < NC; i++) begin
         sum = sum + (PW'(pp_ff[i]) << (i * CH));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= sum;
      end
   end

   assign p = sum_ff;
endmodule

[rtl/ecr_div.sv]
// Restoring divider, one quotient bit per stage; needs num < den * 2^QUO_BITS
module ecr_div #(
   parameter int NUM_BITS = 64,
   parameter int DEN_BITS = 32,
   parameter int QUO_BITS = 16
) (
   input  logic                clock,
   input  logic                en,
   input  logic [NUM_BITS-1:0] num,
   input  logic [DEN_BITS-1:0] den,
   output logic [QUO_BITS-1:0] quo
);
   localparam int EXTW = NUM_BITS + DEN_BITS;

   logic [EXTW-1:0]     num_ext;
   logic [DEN_BITS-1:0] rem_ff [QUO_BITS];
   logic [QUO_BITS-1:0] low_ff [QUO_BITS];
   logic [DEN_BITS-1:0] den_ff [QUO_BITS];
   logic [QUO_BITS-1:0] quo_ff [QUO_BITS];
   logic [DEN_BITS-1:0] rem_prev [QUO_BITS];
   logic [QUO_BITS-1:0] low_prev [QUO_BITS];
   logic [DEN_BITS-1:0] den_prev [QUO_BITS];
   logic [QUO_BITS-1:0] quo_prev [QUO_BITS];

   assign num_ext = EXTW'(num) >> QUO_BITS;

   for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
      logic [DEN_BITS:0] trial;
      logic              ge;

      if (k == 0) begin : g_first
         assign rem_prev[k] = num_ext[DEN_BITS-1:0];
         assign low_prev[k] = num[QUO_BITS-1:0];
         assign den_prev[k] = den;
         assign quo_prev[k] = '0;
      end else begin : g_next
         assign rem_prev[k] = rem_ff[k-1];
         assign low_prev[k] = low_ff[k-1];
         assign den_prev[k] = den_ff[k-1];
         assign quo_prev[k] = quo_ff[k-1];
      end

      // bring down one bit, subtract if it fits
      assign trial = {rem_prev[k], low_prev[k][QUO_BITS-1]};
      assign ge    = (trial >= {1'b0, den_prev[k]});

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? DEN_BITS'(trial - {1'b0, den_prev[k]}) : DEN_BITS'(trial);
            low_ff[k] <= low_prev[k] << 1;
            den_ff[k] <= den_prev[k];
            quo_ff[k] <= {quo_prev[k][QUO_BITS-2:0], ge};
         end
      end
   end

   assign quo = quo_ff[QUO_BITS-1];
endmodule

[rtl/ecr_back.sv]
module ecr_back #(
   parameter int WORD_BITS = 24,
   parameter int MASS_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 head_valid,
   input  logic [12*WORD_BITS+2*MASS_BITS+5:0]  head,
   output logic                                 pop,
   ecr_rsp_if.source                            rsp_bus
);
   localparam int W     = WORD_BITS;
   localparam int M     = MASS_BITS;
   localparam int DW1   = W + 1;
   localparam int DDW   = 2 * W + 2;
   localparam int DOTW  = 2 * W + 3;
   localparam int PRW   = W + M + 1;
   localparam int CNW   = W + M + 2;
   localparam int CAW   = W + M + 1;
   localparam int MSW   = M + 1;
   localparam int AW    = MSW + DDW;
   localparam int DENW  = MSW + DDW;
   localparam int NUMW  = AW + DW1;
   localparam int NRW   = NUMW + 1;
   localparam int CRW   = CAW + 1;
   localparam int QB    = W + 3;
   localparam int FW    = W + 5;
   localparam int LAT   = 9 + QB;
   localparam int SIDEW = 6 * W + 2;

   // unpacked queue head
   logic signed [W-1:0]   p1x, p1y, p2x, p2y, v1x, v1y, v2x, v2y;
   logic [M-1:0]          m1, m2;
   logic signed [DW1-1:0] dx, dy, dvx, dvy;
   ecr_pkg::flag_type     flags;

   assign {p1x, p1y, p2x, p2y, v1x, v1y, v2x, v2y, m1, m2, dx, dy, dvx, dvy, flags} = head;

   logic           adv;
   logic [LAT-1:0] valid_ff;

   // whole pipeline moves unless the output item is stuck
   assign adv = !valid_ff[LAT-1] || rsp_bus.ready;
   assign pop = adv && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[LAT-2:0], head_valid};
      end
   end

   // stage 1: squares, dot terms, weighted position terms, separation magnitudes and signs
   logic signed [DDW-1:0] dxe, dye, dvxe, dvye;
   logic signed [PRW-1:0] p1xe, p1ye, p2xe, p2ye, m1e, m2e;
   logic [DDW-1:0]        sqx_ff, sqy_ff;
   logic signed [DDW-1:0] prx_ff, pry_ff;
   logic signed [PRW-1:0] cxa_ff, cxb_ff, cya_ff, cyb_ff;
   logic [DW1-1:0]        absdx_ff, absdy_ff;
   logic                  sdx_ff, sdy_ff;

   assign dxe  = DDW'(dx);
   assign dye  = DDW'(dy);
   assign dvxe = DDW'(dvx);
   assign dvye = DDW'(dvy);
   assign p1xe = PRW'(p1x);
   assign p1ye = PRW'(p1y);
   assign p2xe = PRW'(p2x);
   assign p2ye = PRW'(p2y);
   assign m1e  = $signed(PRW'(m1));
   assign m2e  = $signed(PRW'(m2));

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx_ff   <= dxe * dxe;
         sqy_ff   <= dye * dye;
         prx_ff   <= dvxe * dxe;
         pry_ff   <= dvye * dye;
         cxa_ff   <= p1xe * m2e;
         cxb_ff   <= p2xe * m1e;
         cya_ff   <= p1ye * m2e;
         cyb_ff   <= p2ye * m1e;
         absdx_ff <= dx[W] ? DW1'(-dx) : DW1'(dx);
         absdy_ff <= dy[W] ? DW1'(-dy) : DW1'(dy);
         sdx_ff   <= dx[W];
         sdy_ff   <= dy[W];
      end
   end

   // stage 2: sums
   logic [DDW-1:0]         dd_ff;
   logic signed [DOTW-1:0] dot_ff;
   logic signed [CNW-1:0]  cnx_ff, cny_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         dd_ff  <= sqx_ff + sqy_ff;
         dot_ff <= DOTW'(prx_ff) + DOTW'(pry_ff);
         cnx_ff <= CNW'(cxa_ff) + CNW'(cxb_ff);
         cny_ff <= CNW'(cya_ff) + CNW'(cyb_ff);
      end
   end

   // stage 3: magnitudes and signs
   logic [DDW-1:0] dd3_ff, dotmag_ff;
   logic           sdot_ff, scx_ff, scy_ff;
   logic [CAW-1:0] cxmag_ff, cymag_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         dd3_ff    <= dd_ff;
         dotmag_ff <= dot_ff[DOTW-1] ? DDW'(-dot_ff) : DDW'(dot_ff);
         sdot_ff   <= dot_ff[DOTW-1];
         cxmag_ff  <= cnx_ff[CNW-1] ? CAW'(-cnx_ff) : CAW'(cnx_ff);
         cymag_ff  <= cny_ff[CNW-1] ? CAW'(-cny_ff) : CAW'(cny_ff);
         scx_ff    <= cnx_ff[CNW-1];
         scy_ff    <= cny_ff[CNW-1];
      end
   end

   // masses aligned with stage 3
   logic [M-1:0]   m1_3, m2_3;
   logic [MSW-1:0] msum3, k1_3, k2_3;

   ecr_delay #(.WIDTH(2 * M), .DEPTH(3)) u_mass_dly (
      .clock(clock), .en(adv), .din({m1, m2}), .dout({m1_3, m2_3})
   );

   assign msum3 = MSW'(m1_3) + MSW'(m2_3);
   assign k1_3  = {m2_3, 1'b0};
   assign k2_3  = {m1_3, 1'b0};

   // stages 4-5: denominator and scaled dot products
   logic [DENW-1:0] den5;
   logic [AW-1:0]   a1_5, a2_5;

   ecr_mul #(.A_BITS(DDW), .B_BITS(MSW)) u_mul_den (
      .clock(clock), .en(adv), .a(dd3_ff), .b(msum3), .p(den5)
   );
   ecr_mul #(.A_BITS(DDW), .B_BITS(MSW)) u_mul_k1 (
      .clock(clock), .en(adv), .a(dotmag_ff), .b(k1_3), .p(a1_5)
   );
   ecr_mul #(.A_BITS(DDW), .B_BITS(MSW)) u_mul_k2 (
      .clock(clock), .en(adv), .a(dotmag_ff), .b(k2_3), .p(a2_5)
   );

   logic [DW1-1:0] absdx5, absdy5;

   ecr_delay #(.WIDTH(2 * DW1), .DEPTH(4)) u_absd_dly (
      .clock(clock), .en(adv), .din({absdx_ff, absdy_ff}), .dout({absdx5, absdy5})
   );

   // stages 6-7: numerators
   logic [NUMW-1:0] num1x7, num1y7, num2x7, num2y7;
   logic [DENW-1:0] den7;

   ecr_mul #(.A_BITS(AW), .B_BITS(DW1)) u_mul_n1x (
      .clock(clock), .en(adv), .a(a1_5), .b(absdx5), .p(num1x7)
   );
   ecr_mul #(.A_BITS(AW), .B_BITS(DW1)) u_mul_n1y (
      .clock(clock), .en(adv), .a(a1_5), .b(absdy5), .p(num1y7)
   );
   ecr_mul #(.A_BITS(AW), .B_BITS(DW1)) u_mul_n2x (
      .clock(clock), .en(adv), .a(a2_5), .b(absdx5), .p(num2x7)
   );
   ecr_mul #(.A_BITS(AW), .B_BITS(DW1)) u_mul_n2y (
      .clock(clock), .en(adv), .a(a2_5), .b(absdy5), .p(num2y7)
   );

   ecr_delay #(.WIDTH(DENW), .DEPTH(2)) u_den_dly (
      .clock(clock), .en(adv), .din(den5), .dout(den7)
   );

   logic [CAW-1:0] cxmag7, cymag7;
   logic [MSW-1:0] msum7;

   ecr_delay #(.WIDTH(2 * CAW + MSW), .DEPTH(4)) u_cont_dly (
      .clock(clock), .en(adv), .din({cxmag_ff, cymag_ff, msum3}),
      .dout({cxmag7, cymag7, msum7})
   );

   // stage 8: add half the divisor for round to nearest
   logic [NRW-1:0]  nr1x_ff, nr1y_ff, nr2x_ff, nr2y_ff;
   logic [DENW-1:0] den8_ff;
   logic [CRW-1:0]  crx_ff, cry_ff;
   logic [MSW-1:0]  cden8_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         nr1x_ff  <= NRW'(num1x7) + NRW'(den7 >> 1);
         nr1y_ff  <= NRW'(num1y7) + NRW'(den7 >> 1);
         nr2x_ff  <= NRW'(num2x7) + NRW'(den7 >> 1);
         nr2y_ff  <= NRW'(num2y7) + NRW'(den7 >> 1);
         den8_ff  <= den7;
         crx_ff   <= CRW'(cxmag7) + CRW'(msum7 >> 1);
         cry_ff   <= CRW'(cymag7) + CRW'(msum7 >> 1);
         cden8_ff <= msum7;
      end
   end

   // dividers
   logic [QB-1:0] q1x, q1y, q2x, q2y, qcx, qcy;

   ecr_div #(.NUM_BITS(NRW), .DEN_BITS(DENW), .QUO_BITS(QB)) u_div_1x (
      .clock(clock), .en(adv), .num(nr1x_ff), .den(den8_ff), .quo(q1x)
   );
   ecr_div #(.NUM_BITS(NRW), .DEN_BITS(DENW), .QUO_BITS(QB)) u_div_1y (
      .clock(clock), .en(adv), .num(nr1y_ff), .den(den8_ff), .quo(q1y)
   );
   ecr_div #(.NUM_BITS(NRW), .DEN_BITS(DENW), .QUO_BITS(QB)) u_div_2x (
      .clock(clock), .en(adv), .num(nr2x_ff), .den(den8_ff), .quo(q2x)
   );
   ecr_div #(.NUM_BITS(NRW), .DEN_BITS(DENW), .QUO_BITS(QB)) u_div_2y (
      .clock(clock), .en(adv), .num(nr2y_ff), .den(den8_ff), .quo(q2y)
   );
   ecr_div #(.NUM_BITS(CRW), .DEN_BITS(MSW), .QUO_BITS(QB)) u_div_cx (
      .clock(clock), .en(adv), .num(crx_ff), .den(cden8_ff), .quo(qcx)
   );
   ecr_div #(.NUM_BITS(CRW), .DEN_BITS(MSW), .QUO_BITS(QB)) u_div_cy (
      .clock(clock), .en(adv), .num(cry_ff), .den(cden8_ff), .quo(qcy)
   );

   // quotient signs
   logic sdx3, sdy3, sgx, sgy, scx_d, scy_d;

   ecr_delay #(.WIDTH(2), .DEPTH(2)) u_sd_dly (
      .clock(clock), .en(adv), .din({sdx_ff, sdy_ff}), .dout({sdx3, sdy3})
   );
   ecr_delay #(.WIDTH(4), .DEPTH(5 + QB)) u_sign_dly (
      .clock(clock), .en(adv),
      .din({sdot_ff ^ sdx3, sdot_ff ^ sdy3, scx_ff, scy_ff}),
      .dout({sgx, sgy, scx_d, scy_d})
   );

   // original velocities, first position and flags
   logic signed [W-1:0] v1x_d, v1y_d, v2x_d, v2y_d, p1x_d, p1y_d;
   ecr_pkg::flag_type   flags_d;

   ecr_delay #(.WIDTH(SIDEW), .DEPTH(8 + QB)) u_side_dly (
      .clock(clock), .en(adv), .din({v1x, v1y, v2x, v2y, p1x, p1y, flags}),
      .dout({v1x_d, v1y_d, v2x_d, v2y_d, p1x_d, p1y_d, flags_d})
   );

   function automatic logic signed [FW-1:0] apply_sign(input logic [QB-1:0] q, input logic s);
      logic signed [FW-1:0] e;
      e = $signed(FW'(q));
      return s ? -e : e;
   endfunction

   function automatic logic signed [W-1:0] sat(input logic signed [FW-1:0] x);
      logic fits;
      fits = (&x[FW-1:W-1]) || !(|x[FW-1:W-1]);
      if (fits) begin
         return x[W-1:0];
      end else if (x[FW-1]) begin
         return {1'b1, {(W-1){1'b0}}};
      end
      return {1'b0, {(W-1){1'b1}}};
   endfunction

   // output register
   logic signed [W-1:0] nv1x_ff, nv1y_ff, nv2x_ff, nv2y_ff, cx_ff, cy_ff;
   logic                degen_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         nv1x_ff  <= flags_d.degen ? v1x_d : sat(FW'(v1x_d) - apply_sign(q1x, sgx));
         nv1y_ff  <= flags_d.degen ? v1y_d : sat(FW'(v1y_d) - apply_sign(q1y, sgy));
         nv2x_ff  <= flags_d.degen ? v2x_d : sat(FW'(v2x_d) + apply_sign(q2x, sgx));
         nv2y_ff  <= flags_d.degen ? v2y_d : sat(FW'(v2y_d) + apply_sign(q2y, sgy));
         cx_ff    <= flags_d.mass_zero ? p1x_d : sat(apply_sign(qcx, scx_d));
         cy_ff    <= flags_d.mass_zero ? p1y_d : sat(apply_sign(qcy, scy_d));
         degen_ff <= flags_d.degen;
      end
   end

   assign rsp_bus.valid            = valid_ff[LAT-1];
   assign rsp_bus.new_first_vel_x  = nv1x_ff;
   assign rsp_bus.new_first_vel_y  = nv1y_ff;
   assign rsp_bus.new_second_vel_x = nv2x_ff;
   assign rsp_bus.new_second_vel_y = nv2y_ff;
   assign rsp_bus.contact_x        = cx_ff;
   assign rsp_bus.contact_y        = cy_ff;
   assign rsp_bus.degenerate       = degen_ff;

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[LAT-1] && !rsp_bus.ready) |=> $stable(valid_ff))
      else $error("pipeline moved while output stalled");
   a_pop_enters: assert property (@(posedge clock) disable iff (reset)
      pop |=> valid_ff[0])
      else $error("popped item did not enter the pipeline");
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (valid_ff == '0))
      else $error("pipeline not empty after reset");
endmodule

[rtl/elastic_collision_2d_resolver.sv]
// Channel  Port     Direction  Payload
// request  req_bus  in         two positions, two velocities, two masses
// response rsp_bus  out        two new velocities, contact point, degenerate
//
// Takes one item per cycle while the response is not stalled; the one-bit-per-stage
// dividers follow the multiplier stages.
// Reset (synchronous) empties the queue and clears the pipeline valid bits.
// A stalled response freezes the whole back pipeline; the two-entry queue
// keeps accepting until it fills, then req_bus.ready drops.
module elastic_collision_2d_resolver #(
   parameter int WORD_BITS = 24,
   parameter int MASS_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   ecr_req_if.sink    req_bus,
   ecr_rsp_if.source  rsp_bus
);
   localparam int ENTRY_BITS  = 12 * WORD_BITS + 2 * MASS_BITS + 6;
   localparam int QUEUE_DEPTH = 2;

   logic                  queue_full, push, pop, head_valid;
   logic [ENTRY_BITS-1:0] entry, head;

   // classify incoming items
   ecr_front #(.WORD_BITS(WORD_BITS), .MASS_BITS(MASS_BITS)) u_front (
      .req_bus(req_bus), .queue_full(queue_full), .push(push), .entry(entry)
   );

   // decouple front and back
   ecr_queue #(.WIDTH(ENTRY_BITS), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset), .push(push), .wr_data(entry), .pop(pop),
      .full(queue_full), .not_empty(head_valid), .rd_data(head)
   );

   // resolve the collision
   ecr_back #(.WORD_BITS(WORD_BITS), .MASS_BITS(MASS_BITS)) u_back (
      .clock(clock), .reset(reset), .head_valid(head_valid), .head(head),
      .pop(pop), .rsp_bus(rsp_bus)
   );
endmodule

[dv/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WB = 24;
   localparam int MB = 16;
   localparam int RANDOM_ITEMS = 1900;
   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 80;

   localparam logic signed [WB-1:0] W_MAX = {1'b0, {(WB-1){1'b1}}};
   localparam logic signed [WB-1:0] W_MIN = {1'b1, {(WB-1){1'b0}}};
   localparam logic [MB-1:0] M_MAX = {MB{1'b1}};

   typedef struct {
      logic signed [WB-1:0] p1x, p1y, p2x, p2y, v1x, v1y, v2x, v2y;
      logic [MB-1:0]        m1, m2;
   } pair_type;

   typedef struct {
      logic signed [WB-1:0] n1x, n1y, n2x, n2y, cx, cy;
      logic                 degen;
   } impact_type;

   // Predicts post-impact velocities and contact point and holds them until the block answers
   class impact_scoreboard;
      impact_type pending[$];
      int         errors = 0;

      static function logic signed [WB-1:0] clamp(longint v);
         if (v > longint'(W_MAX)) return W_MAX;
         if (v < longint'(W_MIN)) return W_MIN;
         return v[WB-1:0];
      endfunction

      // signed quotient, rounded to nearest with ties away from zero
      static function longint round_quot(logic signed [127:0] num,
                                         logic signed [127:0] den);
         logic signed [127:0] mag, q;
         mag = (num < 0) ? -num : num;
         q = (mag + den / 2) / den;
         return (num < 0) ? -longint'(q) : longint'(q);
      endfunction

      static function longint weigh(longint a, longint wa, longint b, longint wb,
                                    longint total);
         longint n;
         n = a * wa + b * wb;
         if (n < 0) return -((-n + total / 2) / total);
         return (n + total / 2) / total;
      endfunction

      static function impact_type resolve(pair_type p);
         impact_type r;
         longint m1, m2, msum, dx, dy;
         longint n1x, n1y, n2x, n2y, cx, cy;
         logic signed [127:0] wdx, wdy, dd, dot, den, k1, k2;
         m1 = p.m1; m2 = p.m2; msum = m1 + m2;
         dx = longint'(p.p1x) - longint'(p.p2x);
         dy = longint'(p.p1y) - longint'(p.p2y);
         n1x = p.v1x; n1y = p.v1y; n2x = p.v2x; n2y = p.v2y;
         cx = p.p1x; cy = p.p1y;
         if (msum != 0) begin
            cx = weigh(p.p1x, m2, p.p2x, m1, msum);
            cy = weigh(p.p1y, m2, p.p2y, m1, msum);
         end
         r.degen = (msum == 0) || (dx == 0 && dy == 0);
         if (!r.degen) begin
            wdx = dx; wdy = dy;
            dd = wdx * wdx + wdy * wdy;
            dot = (n1x - n2x) * wdx + (n1y - n2y) * wdy;
            den = msum * dd;
            k1 = 2 * m2 * dot;
            k2 = 2 * m1 * dot;
            n1x = n1x - round_quot(k1 * wdx, den);
            n1y = n1y - round_quot(k1 * wdy, den);
            n2x = n2x + round_quot(k2 * wdx, den);
            n2y = n2y + round_quot(k2 * wdy, den);
         end
         r.n1x = clamp(n1x); r.n1y = clamp(n1y);
         r.n2x = clamp(n2x); r.n2y = clamp(n2y);
         r.cx = clamp(cx); r.cy = clamp(cy);
         return r;
      endfunction

      function void note_pair(pair_type p);
         pending.insert(pending.size(), resolve(p));
      endfunction

      function void compare(string name, longint exp_v, longint act_v);
         if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_impact(impact_type a);
         impact_type e;
         if (pending.size() == 0) begin
            $error("response with no item outstanding");
            errors++;
            return;
         end
         e = pending.pop_front();
         compare("new_first_vel_x", e.n1x, a.n1x);
         compare("new_first_vel_y", e.n1y, a.n1y);
         compare("new_second_vel_x", e.n2x, a.n2x);
         compare("new_second_vel_y", e.n2y, a.n2y);
         compare("contact_x", e.cx, a.cx);
         compare("contact_y", e.cy, a.cy);
         compare("degenerate", e.degen, a.degen);
      endfunction
   endclass

   logic clock;
   logic reset;
   ecr_req_if #(.WORD_BITS(WB), .MASS_BITS(MB)) req_bus ();
   ecr_rsp_if #(.WORD_BITS(WB)) rsp_bus ();

   elastic_collision_2d_resolver #(.WORD_BITS(WB), .MASS_BITS(MB)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   impact_scoreboard sb = new();
   bit stim_done = 0;
   int idle_cycles = 0;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Hold every input at a known value from time zero
   initial begin
      reset = 1;
      req_bus.valid = 0;
      {req_bus.first_pos_x, req_bus.first_pos_y, req_bus.second_pos_x,
       req_bus.second_pos_y, req_bus.first_vel_x, req_bus.first_vel_y,
       req_bus.second_vel_x, req_bus.second_vel_y} = '0;
      req_bus.first_mass = '0;
      req_bus.second_mass = '0;
      rsp_bus.ready = 0;
   end

   // Note accepted items and check returned ones
   always @(posedge clock) begin
      pair_type   p;
      impact_type a;
      if (!reset && req_bus.valid && req_bus.ready) begin
         p.p1x = req_bus.first_pos_x;  p.p1y = req_bus.first_pos_y;
         p.p2x = req_bus.second_pos_x; p.p2y = req_bus.second_pos_y;
         p.v1x = req_bus.first_vel_x;  p.v1y = req_bus.first_vel_y;
         p.v2x = req_bus.second_vel_x; p.v2y = req_bus.second_vel_y;
         p.m1 = req_bus.first_mass;    p.m2 = req_bus.second_mass;
         sb.note_pair(p);
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         a.n1x = rsp_bus.new_first_vel_x;  a.n1y = rsp_bus.new_first_vel_y;
         a.n2x = rsp_bus.new_second_vel_x; a.n2y = rsp_bus.new_second_vel_y;
         a.cx = rsp_bus.contact_x;         a.cy = rsp_bus.contact_y;
         a.degen = rsp_bus.degenerate;
         sb.check_impact(a);
      end
   end

   // End the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || stim_done || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Stall the response side at random, with stall-free stretches
   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_bus.ready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   // Drive one item after a random gap, unless no_gap is set, and hold it until accepted
   task automatic send_pair(pair_type p, bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_bus.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1;
      req_bus.first_pos_x <= p.p1x;  req_bus.first_pos_y <= p.p1y;
      req_bus.second_pos_x <= p.p2x; req_bus.second_pos_y <= p.p2y;
      req_bus.first_vel_x <= p.v1x;  req_bus.first_vel_y <= p.v1y;
      req_bus.second_vel_x <= p.v2x; req_bus.second_vel_y <= p.v2y;
      req_bus.first_mass <= p.m1;    req_bus.second_mass <= p.m2;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   function automatic logic signed [WB-1:0] any_word(int span);
      case ($urandom_range(0, 5))
         0: return W_MAX;
         1: return W_MIN;
         2: return '0;
         3: return $urandom_range(0, 1) ? WB'(1) : WB'(-1);
         4: return WB'($signed($urandom_range(0, 2 * span)) - span);
         default: return WB'($urandom());
      endcase
   endfunction

   function automatic pair_type random_pair();
      pair_type p;
      int span;
      int kind;
      span = 1 << $urandom_range(2, 22);
      kind = $urandom_range(0, 9);
      p.p1x = any_word(span); p.p1y = any_word(span);
      p.p2x = any_word(span); p.p2y = any_word(span);
      p.v1x = any_word(span); p.v1y = any_word(span);
      p.v2x = any_word(span); p.v2y = any_word(span);
      p.m1 = MB'($urandom()); p.m2 = MB'($urandom());
      case (kind)
         0: begin p.p2x = p.p1x; p.p2y = p.p1y; end
         1: begin p.m1 = '0; p.m2 = '0; end
         2: if ($urandom_range(0, 1)) p.m1 = '0; else p.m2 = '0;
         3: begin
            // near neighbors: short separation, small masses
            p.p2x = WB'(p.p1x + $signed($urandom_range(0, 16)) - 8);
            p.p2y = WB'(p.p1y + $signed($urandom_range(0, 16)) - 8);
            p.m1 = MB'($urandom_range(0, 1024)); p.m2 = MB'($urandom_range(0, 1024));
         end
         default: ;
      endcase
      return p;
   endfunction

   function automatic pair_type make_pair(logic signed [WB-1:0] p1x, p1y, p2x, p2y,
                                          logic signed [WB-1:0] v1x, v1y, v2x, v2y,
                                          logic [MB-1:0] m1, m2);
      pair_type p;
      p.p1x = p1x; p.p1y = p1y; p.p2x = p2x; p.p2y = p2y;
      p.v1x = v1x; p.v1y = v1y; p.v2x = v2x; p.v2y = v2y;
      p.m1 = m1; p.m2 = m2;
      return p;
   endfunction

   task automatic wait_drained();
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   // Stimulus: directed corners, then random pairs
   initial begin
      pair_type directed[$];
      repeat (2) @(posedge clock);
      reset <= 0;

      directed = {directed, make_pair(0, 0, 256, 0, 256, 0, -256, 0, 256, 256)};
      directed = {directed, make_pair(0, 0, 256, 256, 512, 0, 0, 0, 256, 512)};
      directed = {directed, make_pair(W_MAX, W_MAX, W_MIN, W_MIN, W_MAX, W_MAX,
                                      W_MIN, W_MIN, M_MAX, M_MAX)};
      directed = {directed, make_pair(W_MIN, W_MIN, W_MAX, W_MAX, W_MIN, W_MIN,
                                      W_MAX, W_MAX, M_MAX, 1)};
      directed = {directed, make_pair(1, 0, 0, 0, W_MAX, 0, W_MIN, 0, M_MAX, M_MAX)};
      directed = {directed, make_pair(0, 1, 0, 0, 0, W_MIN, 0, W_MAX, 1, M_MAX)};
      directed = {directed, make_pair(100, -50, 100, -50, 7, 8, 9, 10, 256, 256)};
      directed = {directed, make_pair(W_MAX, W_MIN, W_MAX, W_MIN, 1, -1, -1, 1, 0, 0)};
      directed = {directed, make_pair(300, 400, -300, -400, 11, 12, 13, 14, 0, 0)};
      directed = {directed, make_pair(300, 400, -300, -400, 500, -9, -3, 77, 0, 512)};
      directed = {directed, make_pair(300, 400, -300, -400, 500, -9, -3, 77, 512, 0)};
      directed = {directed, make_pair(1, 1, 0, 0, 1, 0, 0, 0, 1, 1)};
      directed = {directed, make_pair(-1, 0, 0, 0, 0, 0, 1, 0, 1, 2)};
      directed = {directed, make_pair(3, 0, 0, 0, -1, 0, 0, 0, 1, 1)};
      directed = {directed, make_pair(W_MAX, 0, W_MIN, 0, 0, 0, 0, 0, 1, 0)};
      directed = {directed, make_pair(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MIN,
                                      W_MIN, W_MAX, M_MAX, 0)};
      directed = {directed, make_pair(1, 2, 4, 8, -16, 32, -64, 128, 3, 5)};
      foreach (directed[i]) send_pair(directed[i], 0);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         // back-to-back bursts for stretches without gaps
         send_pair(random_pair(), (i % 200) < 40);
         if (i == RANDOM_ITEMS / 2) begin
            req_bus.valid <= 0;
            @(posedge clock);
            wait_drained();
         end
      end
      req_bus.valid <= 0;

      wait_drained();
      stim_done = 1;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
